// ----- src/pidwi_pkg.sv -----
// ----------------------------------------------------------------------------
// pidwi_pkg
// Shared types and constants for the windowed-integral PID core.
// ----------------------------------------------------------------------------
`default_nettype none
package pidwi_pkg;

  localparam int DATA_W   = 32;
  localparam int PROD_W   = 64;
  localparam int TERM_W   = 48;
  localparam int SUM_W    = 50;
  localparam int DIVD_W   = 42;
  localparam int CNT_W    = 6;
  localparam int CFG_IW   = 3;
  localparam logic [30:0] WINDOW_RESET = 31'd196608;

  localparam logic [CFG_IW-1:0] CFG_GAIN_P   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_GAIN_I   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_GAIN_D   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_CLAMP_EN = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_OUT_MIN  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_OUT_MAX  = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_WINDOW   = 3'd6;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;
    logic        [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               limited;
    logic               zero_interval;
  } result_t;

  typedef struct packed {
    logic load;
    logic calc_err;
    logic mul_p;
    logic mul_i;
    logic integrate;
    logic div_step;
    logic rate;
    logic mul_d;
    logic sum;
    logic clamp;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- src/pidwi_ctrl.sv -----
// ----------------------------------------------------------------------------
// pidwi_ctrl
// Sequencer: steps the datapath through one sample and runs the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
module pidwi_ctrl import pidwi_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       sample_valid,
  output logic            sample_ready,
  output logic            result_valid,
  input  wire logic       result_ready,
  output dp_cmd_t         cmd,
  input  wire dp_status_t status
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_ERR  = 11'b00000000010,
    S_MULP = 11'b00000000100,
    S_MULI = 11'b00000001000,
    S_INTG = 11'b00000010000,
    S_DIV  = 11'b00000100000,
    S_RATE = 11'b00001000000,
    S_MULD = 11'b00010000000,
    S_SUM  = 11'b00100000000,
    S_CLMP = 11'b01000000000,
    S_HOLD = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load = sample_valid;
        if (sample_valid) state_next = S_ERR;
      end
      S_ERR:  begin cmd.calc_err = 1'b1;  state_next = S_MULP; end
      S_MULP: begin cmd.mul_p = 1'b1;     state_next = S_MULI; end
      S_MULI: begin cmd.mul_i = 1'b1;     state_next = S_INTG; end
      S_INTG: begin cmd.integrate = 1'b1; state_next = S_DIV;  end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_next = S_RATE;
      end
      S_RATE: begin cmd.rate = 1'b1;      state_next = S_MULD; end
      S_MULD: begin cmd.mul_d = 1'b1;     state_next = S_SUM;  end
      S_SUM:  begin cmd.sum = 1'b1;       state_next = S_CLMP; end
      S_CLMP: begin cmd.clamp = 1'b1;     state_next = S_HOLD; end
      S_HOLD: begin
        if (result_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign sample_ready = (state == S_IDLE);
  assign result_valid = (state == S_HOLD);

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && status.div_done) |=> state == S_RATE)
    else $error("divider exit missed");
  a_load_err: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.calc_err)
    else $error("load not followed by error step");
  a_clamp_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.clamp |=> result_valid)
    else $error("result not presented after clamp");

endmodule
`default_nettype wire

// ----- src/pidwi_dp.sv -----
// ----------------------------------------------------------------------------
// pidwi_dp
// Datapath: config registers, loop state, shared multiplier, serial divider.
// ----------------------------------------------------------------------------
`default_nettype none
module pidwi_dp import pidwi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire sample_t           sample,
  output result_t                result,
  input  wire dp_cmd_t           cmd,
  output dp_status_t             status
);

  logic signed [31:0] gain_p, gain_i, gain_d, out_min, out_max;
  logic               clamp_enable;
  logic [30:0]        integral_window;

  logic signed [31:0] integral_sum, prior_error;
  logic [31:0]        prior_tick;

  sample_t                   smp;
  logic signed [31:0]        err, rate;
  logic [31:0]               elapsed;
  logic                      zero_iv, neg;
  logic signed [PROD_W-1:0]  prod;
  logic signed [TERM_W-1:0]  p_term;
  logic signed [SUM_W-1:0]   sum;
  logic [32:0]               rem;
  logic [DIVD_W-1:0]         quo;
  logic [CNT_W-1:0]          cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= '0; gain_i <= '0; gain_d <= '0;
      out_min <= '0; out_max <= '0; clamp_enable <= 1'b0;
      integral_window <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_P:   gain_p <= cfg_data;
        CFG_GAIN_I:   gain_i <= cfg_data;
        CFG_GAIN_D:   gain_d <= cfg_data;
        CFG_CLAMP_EN: clamp_enable <= cfg_data[0];
        CFG_OUT_MIN:  out_min <= cfg_data;
        CFG_OUT_MAX:  out_max <= cfg_data;
        CFG_WINDOW:   integral_window <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // error, saturated
  logic signed [32:0] diff_raw;
  logic signed [31:0] err_sat;
  assign diff_raw = 33'(smp.measured) - 33'(smp.setpoint);
  always_comb begin
    if (diff_raw > 33'sh0_7FFF_FFFF)       err_sat = 32'sh7FFF_FFFF;
    else if (diff_raw < -33'sh0_8000_0000) err_sat = 32'sh8000_0000;
    else                                   err_sat = diff_raw[31:0];
  end

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  always_comb begin
    case (1'b1)
      cmd.mul_i: begin mul_a = gain_i; mul_b = err;  end
      cmd.mul_d: begin mul_a = gain_d; mul_b = rate; end
      default:   begin mul_a = gain_p; mul_b = err;  end
    endcase
  end

  // error delta times 1000, magnitude
  logic signed [32:0] de;
  logic [32:0]        de_mag;
  logic [DIVD_W-1:0]  dvd;
  assign de     = 33'(err) - 33'(prior_error);
  assign de_mag = de[32] ? 33'(-de) : de;
  assign dvd    = (DIVD_W'(de_mag) << 10) - (DIVD_W'(de_mag) << 4) - (DIVD_W'(de_mag) << 3);

  // integral update
  logic signed [32:0] win_s;
  logic               in_win;
  logic signed [48:0] isum_new;
  assign win_s    = 33'($signed({2'b00, integral_window}));
  assign in_win   = (33'(err) <= win_s) && (33'(err) >= -win_s);
  assign isum_new = 49'(integral_sum) + 49'($signed(prod[PROD_W-1:16]));

  // divider step
  logic [32:0] rem_sh;
  logic        fits;
  assign rem_sh = {rem[31:0], quo[DIVD_W-1]};
  assign fits   = rem_sh >= {1'b0, elapsed};
  assign status.div_done = (cnt == '0);

  // clamp / saturate
  logic signed [SUM_W-1:0] t1;
  logic                    above, below;
  assign above = sum > SUM_W'(out_max);
  assign t1    = above ? SUM_W'(out_max) : sum;
  assign below = t1 < SUM_W'(out_min);

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      prior_error  <= '0;
      prior_tick   <= '0;
      cnt          <= '0;
    end else begin
      if (cmd.load) smp <= sample;
      if (cmd.calc_err) begin
        err     <= err_sat;
        elapsed <= smp.now_ms - prior_tick;
        zero_iv <= (smp.now_ms == prior_tick);
      end
      if (cmd.mul_p || cmd.mul_i || cmd.mul_d) prod <= mul_a * mul_b;
      if (cmd.mul_p) begin
        quo <= dvd;
        neg <= de[32];
        rem <= '0;
        cnt <= CNT_W'(DIVD_W);
      end
      if (cmd.mul_i) p_term <= prod[PROD_W-1:16];
      if (cmd.integrate) begin
        if (in_win) begin
          if (isum_new > 49'sh0_7FFF_FFFF)       integral_sum <= 32'sh7FFF_FFFF;
          else if (isum_new < -49'sh0_8000_0000) integral_sum <= 32'sh8000_0000;
          else                                   integral_sum <= isum_new[31:0];
        end
        prior_error <= err;
        prior_tick  <= smp.now_ms;
      end
      if (cmd.div_step && cnt != '0) begin
        rem <= fits ? rem_sh - {1'b0, elapsed} : rem_sh;
        quo <= {quo[DIVD_W-2:0], fits};
        cnt <= cnt - 1'b1;
      end
      if (cmd.rate) begin
        if (!neg) rate <= (quo > DIVD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : quo[31:0];
        else      rate <= (quo > DIVD_W'(32'h8000_0000)) ? 32'sh8000_0000 : -quo[31:0];
      end
      if (cmd.sum)
        sum <= SUM_W'(p_term) + SUM_W'(integral_sum)
             + (zero_iv ? '0 : SUM_W'($signed(prod[PROD_W-1:16])));
      if (cmd.clamp) begin
        result.zero_interval <= zero_iv;
        if (clamp_enable) begin
          result.drive   <= below ? out_min : t1[31:0];
          result.limited <= above | below;
        end else if (sum > SUM_W'(32'sh7FFF_FFFF)) begin
          result.drive <= 32'sh7FFF_FFFF; result.limited <= 1'b1;
        end else if (sum < SUM_W'(32'sh8000_0000)) begin
          result.drive <= 32'sh8000_0000; result.limited <= 1'b1;
        end else begin
          result.drive <= sum[31:0]; result.limited <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/pid_controller_windowed_integral_core.sv -----
// ----------------------------------------------------------------------------
// pid_controller_windowed_integral_core
// PID controller with a windowed integral and optional output clamp.
// ----------------------------------------------------------------------------
// One word at a time: a sample is taken when the core is idle and its result
// word appears once the sequencer has run all its steps, held until taken;
// the next sample is taken the cycle after. The sequence runs the 42-step
// bit-serial divider for the derivative rate and makes three passes through
// one shared 32x32 multiplier.
`default_nettype none
module pid_controller_windowed_integral_core import pidwi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic              sample_valid,
  output logic                   sample_ready,
  input  wire sample_t           sample,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output result_t                result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  pidwi_ctrl u_ctrl (
    .clk, .rst, .sample_valid, .sample_ready, .result_valid, .result_ready,
    .cmd, .status
  );

  pidwi_dp u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .sample, .result, .cmd, .status
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !sample_ready)
    else $error("sample taken while result pending");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> !sample_ready)
    else $error("second sample taken while busy");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready) |=> !result_valid)
    else $error("result repeated");

endmodule
`default_nettype wire
